@@ sv/range_min_argmin_tree_assert.svh @@
// ----------------------------------------------------------------------------
// range_min_argmin_tree_assert.svh
// Assertion macros for the range minimum tree; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RANGE_MIN_ARGMIN_TREE_ASSERT_SVH
`define RANGE_MIN_ARGMIN_TREE_ASSERT_SVH

`ifndef SYNTHESIS
`define RMAT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range_min_argmin_tree: assertion failed");
`define RMAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range_min_argmin_tree: assertion failed");
`else
`define RMAT_ASSERT_IMPL(label, ante, cons)
`define RMAT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/rmat_pkg.sv @@
// ----------------------------------------------------------------------------
// rmat_pkg
// Shared types and constants of the range minimum tree.
// ----------------------------------------------------------------------------
package rmat_pkg;

  localparam int VALUE_W = 34;
  localparam int IDX_W   = 11;
  localparam int ADDR_W  = 3;

  localparam logic [VALUE_W-1:0] INF_VALUE     = 34'd10000000000;
  localparam logic [IDX_W-1:0]   ENTRIES_RESET = 11'd1024;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [ADDR_W-3:0] REG_ENTRIES = 1'b0;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   first_index;
    logic [IDX_W-1:0]   last_index;
    logic [VALUE_W-1:0] new_value;
  } cmd_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0] min_value;
    logic [IDX_W-1:0]   min_index;
    logic               range_error;
  } rsp_word_t;

  typedef struct packed {
    logic active;
    logic last;
  } clr_ctl_t;

endpackage

@@ sv/rmat_ram.sv @@
// ----------------------------------------------------------------------------
// rmat_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rmat_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rmat_cfg.sv @@
// ----------------------------------------------------------------------------
// rmat_cfg
// APB register slave holding the count of entries in use.
// ----------------------------------------------------------------------------
module rmat_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rmat_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [rmat_pkg::IDX_W-1:0] entries
);
  import rmat_pkg::*;

  logic sel_entries;

  assign sel_entries = (paddr[ADDR_W-1:2] == REG_ENTRIES);
  assign pready      = 1'b1;
  assign prdata      = sel_entries ? 32'(entries) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= ENTRIES_RESET;
    end else if (psel && penable && pwrite && sel_entries) begin
      entries <= pwdata[IDX_W-1:0];
    end
  end

endmodule

@@ sv/rmat_clear.sv @@
// ----------------------------------------------------------------------------
// rmat_clear
// Post-reset sweep over the node memory, top address down to zero, giving
// each node its address and the offset of the highest leaf below it.
// ----------------------------------------------------------------------------
module rmat_clear #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  output rmat_pkg::clr_ctl_t               ctl,
  output logic [$clog2(MAX_ENTRIES):0]     addr,
  output logic [$clog2(MAX_ENTRIES)-1:0]   leaf
);
  import rmat_pkg::*;

  localparam int LW = $clog2(MAX_ENTRIES);
  localparam int AW = LW + 1;

  logic          active;
  logic [AW-1:0] base;
  logic [LW:0]   step;

  assign ctl.active = active;
  assign ctl.last   = active && (addr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      addr   <= '1;
      base   <= AW'(MAX_ENTRIES);
      step   <= (LW+1)'(1);
      leaf   <= '1;
    end else if (active) begin
      addr <= addr - AW'(1);
      if (addr == '0) begin
        active <= 1'b0;
      end
      if (addr == base) begin
        base <= base >> 1;
        step <= step << 1;
        leaf <= '1;
      end else begin
        leaf <= leaf - step[LW-1:0];
      end
    end
  end

endmodule

@@ sv/range_min_argmin_tree.sv @@
// ----------------------------------------------------------------------------
// range_min_argmin_tree
// Minimum/argmin segment tree over entries 1..n held in one node memory.
// ----------------------------------------------------------------------------
// Point updates and inclusive range-minimum queries over a bottom-up tree
// of 2*MAX_ENTRIES nodes (MAX_ENTRIES a power of two), each node holding the
// minimum below it and the offset of its winning leaf; ties go to the higher
// index. All reads go through the single read port of the node memory.
// An update does one leaf write, then one sibling read and parent write per
// level. A query walks the tree upward, checking the lower bound in S_QLO and
// the upper bound in S_QHI at each level. A rejected word goes straight to
// S_DONE. A query or rejected word also waits while the previous result
// word is still stalled. After reset a clearing pass over all 2*MAX_ENTRIES
// nodes runs before the first word is taken; register writes go on meanwhile.
// ----------------------------------------------------------------------------
`include "range_min_argmin_tree_assert.svh"

module range_min_argmin_tree #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_stall,
  input  rmat_pkg::cmd_word_t         cmd,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output rmat_pkg::rsp_word_t         rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rmat_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import rmat_pkg::*;

  localparam int LW = $clog2(MAX_ENTRIES);
  localparam int AW = LW + 1;
  localparam int PW = AW + 1;
  localparam int DW = VALUE_W + LW;
  localparam int MAX_N_INT = (MAX_ENTRIES > 2047) ? 2047 : MAX_ENTRIES;
  localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_N_INT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ULEAF = 3'd2;
  localparam logic [2:0] S_UUP   = 3'd3;
  localparam logic [2:0] S_QLO   = 3'd4;
  localparam logic [2:0] S_QHI   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  function automatic logic takes_b(logic [VALUE_W-1:0] av, logic [LW-1:0] ai,
                                   logic [VALUE_W-1:0] bv, logic [LW-1:0] bi);
    return (bv < av) || ((bv == av) && (bi > ai));
  endfunction

  logic [2:0]         state;
  logic [IDX_W-1:0]   entries;
  logic [IDX_W-1:0]   n_lim;
  clr_ctl_t           clr_ctl;
  logic [AW-1:0]      clr_addr;
  logic [LW-1:0]      clr_leaf;

  logic               we, re;
  logic [AW-1:0]      waddr, raddr;
  logic [DW-1:0]      wdata, rdata;
  logic [VALUE_W-1:0] rd_v;
  logic [LW-1:0]      rd_i;

  logic [AW-1:0]      pos, par;
  logic [VALUE_W-1:0] carry_v, mrg_v, acc_v;
  logic [LW-1:0]      carry_i, mrg_i, acc_i;
  logic [PW-1:0]      lo, hi, hi_m1;
  logic               lo_lt_hi, rd_pend, err;
  logic               upd_bad, qry_bad;
  rsp_word_t          res;

  rmat_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .entries (entries)
  );

  rmat_clear #(.MAX_ENTRIES(MAX_ENTRIES)) u_clear (
    .clk  (clk),
    .rst  (rst),
    .ctl  (clr_ctl),
    .addr (clr_addr),
    .leaf (clr_leaf)
  );

  rmat_ram #(.WIDTH(DW), .DEPTH(2 * MAX_ENTRIES)) u_nodes (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_lim     = (entries > MAX_N) ? MAX_N : entries;
  assign upd_bad   = (cmd.first_index == '0) || (cmd.first_index > n_lim);
  assign qry_bad   = (cmd.first_index == '0) || (cmd.last_index > n_lim) ||
                     (cmd.first_index > cmd.last_index);
  assign cmd_stall = (state != S_IDLE);

  assign rd_v     = rdata[DW-1:LW];
  assign rd_i     = rdata[LW-1:0];
  assign par      = pos >> 1;
  assign lo_lt_hi = (lo < hi);
  assign hi_m1    = hi - PW'(1);

  always_comb begin
    if (takes_b(carry_v, carry_i, rd_v, rd_i)) begin
      mrg_v = rd_v;
      mrg_i = rd_i;
    end else begin
      mrg_v = carry_v;
      mrg_i = carry_i;
    end
  end

  always_comb begin
    if (err) begin
      res = '{min_value: '0, min_index: '0, range_error: 1'b1};
    end else begin
      res = '{min_value: acc_v,
              min_index: IDX_W'({1'b0, acc_i} + (LW+1)'(1)),
              range_error: 1'b0};
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = {INF_VALUE, clr_leaf};
      end
      S_ULEAF: begin
        we    = 1'b1;
        waddr = pos;
        wdata = {carry_v, carry_i};
        re    = 1'b1;
        raddr = pos ^ AW'(1);
      end
      S_UUP: begin
        we    = 1'b1;
        waddr = par;
        wdata = {mrg_v, mrg_i};
        re    = (par != AW'(1));
        raddr = par ^ AW'(1);
      end
      S_QLO: begin
        re    = lo_lt_hi && lo[0];
        raddr = lo[AW-1:0];
      end
      S_QHI: begin
        re    = hi[0];
        raddr = hi_m1[AW-1:0];
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= re && ((state == S_QLO) || (state == S_QHI));
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      if (rd_pend && takes_b(acc_v, acc_i, rd_v, rd_i)) begin
        acc_v <= rd_v;
        acc_i <= rd_i;
      end
      case (state)
        S_CLEAR: begin
          if (clr_ctl.last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            pos     <= AW'(MAX_ENTRIES) + AW'(cmd.first_index) - AW'(1);
            carry_v <= cmd.new_value;
            carry_i <= LW'(cmd.first_index - IDX_W'(1));
            lo      <= PW'(MAX_ENTRIES) + PW'(cmd.first_index) - PW'(1);
            hi      <= PW'(MAX_ENTRIES) + PW'(cmd.last_index);
            acc_v   <= '1;
            acc_i   <= '0;
            err     <= (cmd.op == OP_UPDATE) ? upd_bad : qry_bad;
            if (cmd.op == OP_UPDATE) begin
              if (upd_bad) begin
                state <= S_DONE;
              end else begin
                state <= S_ULEAF;
              end
            end else begin
              if (qry_bad) begin
                state <= S_DONE;
              end else begin
                state <= S_QLO;
              end
            end
          end
        end
        S_ULEAF: begin
          state <= S_UUP;
        end
        S_UUP: begin
          carry_v <= mrg_v;
          carry_i <= mrg_i;
          pos     <= par;
          if (par == AW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_QLO: begin
          if (lo_lt_hi) begin
            if (lo[0]) begin
              lo <= lo + PW'(1);
            end
            state <= S_QHI;
          end else begin
            state <= S_DONE;
          end
        end
        S_QHI: begin
          lo    <= lo >> 1;
          hi    <= hi >> 1;
          state <= S_QLO;
        end
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `RMAT_ASSERT_IMPL(a_no_same_entry_rw, we && re, waddr != raddr)
  `RMAT_ASSERT_IMPL(a_climb_above_root, state == S_UUP, pos != AW'(1))
  `RMAT_ASSERT_NEXT(a_result_issued, (state == S_DONE) && !(rsp_valid && rsp_stall), rsp_valid)
  `RMAT_ASSERT_NEXT(a_clear_ends, (state == S_CLEAR) && clr_ctl.last, (state == S_IDLE) && !clr_ctl.active)

endmodule
